>>> design/resp_stream_tokenizer_top_defines.svh
// Assertion helpers used by the tokenizer output buffer.
`ifndef RESP_STREAM_TOKENIZER_TOP_DEFINES_SVH
`define RESP_STREAM_TOKENIZER_TOP_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define RTOK_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define RTOK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rtok_pkg.sv
package rtok_pkg;

    typedef enum logic [2:0] {
        PH_TYPE      = 3'd0,
        PH_LINE      = 3'd1,
        PH_LINE_CR   = 3'd2,
        PH_NUM_START = 3'd3,
        PH_NUM_BODY  = 3'd4,
        PH_NUM_CR    = 3'd5,
        PH_BULK      = 3'd6,
        PH_TRAILER   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        LT_SIMPLE = 3'd0,
        LT_ERROR  = 3'd1,
        LT_INT    = 3'd4,
        LT_BULK   = 3'd5,
        LT_ARRAY  = 3'd6
    } line_type_t;

    typedef enum logic [3:0] {
        K_SIMPLE = 4'd0,
        K_ERRB   = 4'd1,
        K_BULKB  = 4'd2,
        K_END    = 4'd3,
        K_INT    = 4'd4,
        K_BHDR   = 4'd5,
        K_AHDR   = 4'd6,
        K_NULL   = 4'd7,
        K_FERR   = 4'd8
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] value;
        logic [7:0]  cbyte;
        logic [3:0]  nest;
        logic        done;
        logic        last;
    } token_t;

    typedef struct packed {
        logic   v0;
        logic   v1;
        token_t t0;
        token_t t1;
    } push_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [24:0] MAX_BULK_RESET = 25'd16777216;
    localparam logic [13:0] MAX_ARR_RESET  = 14'd10000;

    // Largest accumulator that still takes one more digit without overflow.
    localparam logic [63:0] NUM_Q = 64'd922337203685477580;

    function automatic token_t mk_token(kind_t k, logic [63:0] v, logic [7:0] b,
                                        logic [3:0] n, logic d);
        token_t t;
        t.kind  = k;
        t.value = v;
        t.cbyte = b;
        t.nest  = n;
        t.done  = d;
        t.last  = 1'b0;
        return t;
    endfunction

endpackage

>>> design/rtok_core.sv
module rtok_core import rtok_pkg::*; #(
    parameter int MAX_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic [24:0] max_bulk,
    input  logic [13:0] max_arr,
    output push_t       push
);

    localparam int LVL_W = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_DEPTH);

    phase_t             phase_reg, phase_next;
    line_type_t         lt_reg, lt_next;
    logic [63:0]        acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               seen_reg, seen_next;
    logic [24:0]        bulk_reg, bulk_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [13:0]        stack_reg [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] ones_reg;

    logic               st_we;
    logic [IDX_W-1:0]   st_idx;
    logic [13:0]        st_wd;

    logic               found;
    logic [IDX_W-1:0]   sel;
    logic [LVL_W-1:0]   cmp_lvl;
    logic [3:0]         nest_cur;
    kind_t              ck;
    logic [3:0]         dig;
    logic [63:0]        thr;
    logic [63:0]        acc10;
    logic [63:0]        m;
    logic               negv;
    logic [63:0]        sval;
    logic               ferr;
    logic               cmpl;
    kind_t              cmpl_kind;
    logic [63:0]        cmpl_val;
    logic               is_digit;
    push_t              p;

    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int k = 0; k < MAX_DEPTH; k++) begin
            if ((LVL_W'(k) < lvl_reg) && !ones_reg[k]) begin
                found = 1'b1;
                sel   = IDX_W'(k);
            end
        end
        cmp_lvl = found ? (LVL_W'(sel) + LVL_W'(1)) : '0;
    end

    assign nest_cur = 4'(lvl_reg);
    assign ck       = (lt_reg == LT_ERROR) ? K_ERRB : K_SIMPLE;
    assign is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);
    assign dig      = 4'(in_byte - CH_0);
    assign thr      = (dig > (neg_reg ? 4'd8 : 4'd7)) ? (NUM_Q - 64'd1) : NUM_Q;
    assign acc10    = (acc_reg << 3) + (acc_reg << 1) + 64'(dig);
    assign m        = acc_reg;
    assign negv     = neg_reg && (m != 64'd0);
    assign sval     = negv ? (64'd0 - m) : m;

    always_comb begin
        phase_next = phase_reg;
        lt_next    = lt_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        bulk_next  = bulk_reg;
        lvl_next   = lvl_reg;
        st_we      = 1'b0;
        st_idx     = sel;
        st_wd      = stack_reg[sel] - 14'd1;
        ferr       = 1'b0;
        cmpl       = 1'b0;
        cmpl_kind  = K_END;
        cmpl_val   = 64'd0;
        p          = '0;

        case (phase_reg)
            PH_TYPE: begin
                acc_next  = 64'd0;
                neg_next  = 1'b0;
                seen_next = 1'b0;
                if (in_byte == CH_PLUS) begin
                    lt_next = LT_SIMPLE;
                    phase_next = PH_LINE;
                end else if (in_byte == CH_MINUS) begin
                    lt_next = LT_ERROR;
                    phase_next = PH_LINE;
                end else if (in_byte == CH_COLON) begin
                    lt_next = LT_INT;
                    phase_next = PH_NUM_START;
                end else if (in_byte == CH_DOLLAR) begin
                    lt_next = LT_BULK;
                    phase_next = PH_NUM_START;
                end else if (in_byte == CH_STAR) begin
                    lt_next = LT_ARRAY;
                    phase_next = PH_NUM_START;
                end else begin
                    ferr = 1'b1;
                end
            end
            PH_LINE: begin
                if (in_byte == CH_CR) begin
                    phase_next = PH_LINE_CR;
                end else begin
                    p.v0 = 1'b1;
                    p.t0 = mk_token(ck, 64'd0, in_byte, nest_cur, 1'b0);
                end
            end
            PH_LINE_CR: begin
                if (in_byte == CH_LF) begin
                    cmpl = 1'b1;
                    cmpl_kind = K_END;
                end else begin
                    p.v0 = 1'b1;
                    p.t0 = mk_token(ck, 64'd0, CH_CR, nest_cur, 1'b0);
                    if (in_byte != CH_CR) begin
                        p.v1 = 1'b1;
                        p.t1 = mk_token(ck, 64'd0, in_byte, nest_cur, 1'b0);
                        phase_next = PH_LINE;
                    end
                end
            end
            PH_NUM_START, PH_NUM_BODY: begin
                if ((phase_reg == PH_NUM_START) &&
                    ((in_byte == CH_PLUS) || (in_byte == CH_MINUS))) begin
                    neg_next = (in_byte == CH_MINUS);
                    phase_next = PH_NUM_BODY;
                end else if (is_digit) begin
                    if (acc_reg > thr) begin
                        ferr = 1'b1;
                    end else begin
                        acc_next = acc10;
                        seen_next = 1'b1;
                        phase_next = PH_NUM_BODY;
                    end
                end else if ((phase_reg == PH_NUM_BODY) && (in_byte == CH_CR) && seen_reg) begin
                    phase_next = PH_NUM_CR;
                end else begin
                    ferr = 1'b1;
                end
            end
            PH_NUM_CR: begin
                if (in_byte != CH_LF) begin
                    ferr = 1'b1;
                end else begin
                    acc_next  = 64'd0;
                    neg_next  = 1'b0;
                    seen_next = 1'b0;
                    if (lt_reg == LT_INT) begin
                        cmpl = 1'b1;
                        cmpl_kind = K_INT;
                        cmpl_val = sval;
                    end else if (negv && (m == 64'd1)) begin
                        cmpl = 1'b1;
                        cmpl_kind = K_NULL;
                        cmpl_val = sval;
                    end else if (lt_reg == LT_BULK) begin
                        if (negv || (m > {39'd0, max_bulk})) begin
                            ferr = 1'b1;
                        end else begin
                            p.v0 = 1'b1;
                            p.t0 = mk_token(K_BHDR, sval, 8'd0, nest_cur, 1'b0);
                            if (m != 64'd0) begin
                                bulk_next = m[24:0];
                                phase_next = PH_BULK;
                            end else begin
                                bulk_next = 25'd2;
                                phase_next = PH_TRAILER;
                            end
                        end
                    end else begin
                        if (negv || (m > {50'd0, max_arr})) begin
                            ferr = 1'b1;
                        end else if (m == 64'd0) begin
                            cmpl = 1'b1;
                            cmpl_kind = K_AHDR;
                        end else if (lvl_reg >= LVL_MAX) begin
                            ferr = 1'b1;
                        end else begin
                            p.v0 = 1'b1;
                            p.t0 = mk_token(K_AHDR, sval, 8'd0, nest_cur, 1'b0);
                            st_we = 1'b1;
                            st_idx = IDX_W'(lvl_reg);
                            st_wd = m[13:0];
                            lvl_next = lvl_reg + LVL_W'(1);
                            phase_next = PH_TYPE;
                        end
                    end
                end
            end
            PH_BULK: begin
                p.v0 = 1'b1;
                p.t0 = mk_token(K_BULKB, 64'd0, in_byte, nest_cur, 1'b0);
                bulk_next = bulk_reg - 25'd1;
                if (bulk_next == 25'd0) begin
                    bulk_next = 25'd2;
                    phase_next = PH_TRAILER;
                end
            end
            default: begin
                bulk_next = bulk_reg - 25'd1;
                if (bulk_next == 25'd0) begin
                    cmpl = 1'b1;
                    cmpl_kind = K_END;
                end
            end
        endcase

        if (cmpl) begin
            p.v0 = 1'b1;
            p.t0 = mk_token(cmpl_kind, cmpl_val, 8'd0, nest_cur, cmp_lvl == '0);
            lvl_next = cmp_lvl;
            phase_next = PH_TYPE;
            st_we = found;
            st_idx = sel;
            st_wd = stack_reg[sel] - 14'd1;
        end

        if (ferr) begin
            p = '0;
            p.v0 = 1'b1;
            p.t0 = mk_token(K_FERR, 64'd0, 8'd0, nest_cur, 1'b0);
            lvl_next = '0;
            phase_next = PH_TYPE;
            bulk_next = 25'd0;
            acc_next = 64'd0;
            neg_next = 1'b0;
            seen_next = 1'b0;
            st_we = 1'b0;
        end

        if (p.v1) begin
            p.t1.last = 1'b1;
        end else begin
            p.t0.last = 1'b1;
        end
        p.v0 = p.v0 & in_valid;
        p.v1 = p.v1 & in_valid;
    end

    assign push = p;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
            lt_reg    <= LT_SIMPLE;
            acc_reg   <= 64'd0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            bulk_reg  <= 25'd0;
            lvl_reg   <= '0;
        end else if (in_valid) begin
            phase_reg <= phase_next;
            lt_reg    <= lt_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            bulk_reg  <= bulk_next;
            lvl_reg   <= lvl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && st_we) begin
            stack_reg[st_idx] <= st_wd;
            ones_reg[st_idx]  <= (st_wd == 14'd1);
        end
    end

endmodule

>>> design/rtok_fifo.sv
module rtok_fifo import rtok_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  push_t  push,
    output logic   room,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t out_tok
);

    `include "resp_stream_tokenizer_top_defines.svh"

    token_t      mem_reg [4];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  rd_ptr_reg;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic        pop;
    logic [2:0]  n_push;

    assign room      = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign out_tok   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = {2'b00, push.v0} + {2'b00, push.v1};
    assign count_next = count_reg + n_push - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + n_push[1:0];
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem_reg[wr_ptr_reg] <= push.t0;
        end
        if (push.v1) begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.t1;
        end
    end

    `RTOK_CHECK(a_count_bound, count_reg <= 3'd4, "Output buffer count exceeds its depth.")
    `RTOK_CHECK(a_push_room, (n_push == 3'd0) || (({1'b0, count_reg} + {1'b0, n_push}) <= 4'd4), "Push overruns the output buffer.")
    `RTOK_CHECK(a_pair_order, !push.v1 || (push.v0 && push.t1.last && !push.t0.last), "Second result of a byte is malformed.")
    `RTOK_NEXT(a_count_track, (n_push == 3'd0) && pop, count_reg == ($past(count_reg) - 3'd1), "Count did not follow a pop.")

endmodule

>>> design/resp_stream_tokenizer_top.sv
// Each result of an accepted byte is registered into the output buffer, and results are
// offered from its head in order; a second result of the same byte follows the first.
// Throughput: one input byte per cycle while the four-entry output buffer holds at most
// two results; results leave it at one per cycle while m_tready is high.
// Reset: aresetn is synchronous and active low; it empties the buffer, restores both
// limits and returns the parser to waiting for a type byte.
module resp_stream_tokenizer_top import rtok_pkg::*; #(
    parameter int MAX_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,     // token_value, content_byte, nest_level, frame_done, zeros
    output logic [3:0]  m_tuser,     // token_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data
);

    logic [24:0] max_bulk_reg;
    logic [13:0] max_arr_reg;
    logic        accept;
    push_t       push;
    token_t      tok;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bulk_reg <= MAX_BULK_RESET;
            max_arr_reg  <= MAX_ARR_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == 1'b0) begin
                max_bulk_reg <= cfg_data;
            end else begin
                max_arr_reg <= cfg_data[13:0];
            end
        end
    end

    rtok_core #(.MAX_DEPTH(MAX_DEPTH)) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (accept),
        .in_byte  (s_tdata),
        .max_bulk (max_bulk_reg),
        .max_arr  (max_arr_reg),
        .push     (push)
    );

    rtok_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (tok)
    );

    assign m_tdata = {3'd0, tok.done, tok.nest, tok.cbyte, tok.value};
    assign m_tuser = tok.kind;
    assign m_tlast = tok.last;

endmodule
